>>> rtl/line_follow_pd_step_assert.svh
// Assertion macros for the line follower RTL. Each expects clk and rst_n in scope.
`ifndef LINE_FOLLOW_PD_STEP_ASSERT_SVH
`define LINE_FOLLOW_PD_STEP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define LFPD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define LFPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lfpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lfpd_pkg;

  typedef logic [2:0] action_t;

  localparam action_t ACT_FOLLOW      = 3'd0;
  localparam action_t ACT_CROSS       = 3'd1;
  localparam action_t ACT_LOST_RIGHT  = 3'd2;
  localparam action_t ACT_LOST_LEFT   = 3'd3;
  localparam action_t ACT_LOST_STRAIT = 3'd4;
  localparam action_t ACT_AVOID       = 3'd5;
  localparam action_t ACT_AVOID_DIAG  = 3'd6;
  localparam action_t ACT_HALTED      = 3'd7;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t CFG_PROP_GAIN   = 3'd0;
  localparam cfg_index_t CFG_DERIV_GAIN  = 3'd1;
  localparam cfg_index_t CFG_CRUISE_DUTY = 3'd2;
  localparam cfg_index_t CFG_CURVE_SLOW  = 3'd3;
  localparam cfg_index_t CFG_STALL_FLOOR = 3'd4;
  localparam cfg_index_t CFG_SPEED_SCALE = 3'd5;
  localparam cfg_index_t CFG_WHITE_LEVEL = 3'd6;
  localparam cfg_index_t CFG_OBST_RANGE  = 3'd7;

  typedef logic [1:0] side_t;

  localparam side_t SIDE_CENTER = 2'd0;
  localparam side_t SIDE_RIGHT  = 2'd1;
  localparam side_t SIDE_LEFT   = 2'd2;

  localparam logic [11:0] FLOOR_SIDE   = 12'd1024;
  localparam logic [11:0] FLOOR_MID    = 12'd2458;
  localparam logic [14:0] LINE_MIN_SUM = 15'd410;
  localparam logic [13:0] NOISE_RANGE  = 14'd32;
  localparam logic [13:0] EMERG_RANGE  = 14'd192;
  localparam logic [13:0] DIAG_RANGE   = 14'd320;
  localparam logic signed [16:0] STEER_LIM = 17'sd65535;
  localparam logic [12:0] Q_ONE        = 13'd4096;

  localparam logic [13:0] RST_PROP_GAIN   = 14'd1434;
  localparam logic [13:0] RST_DERIV_GAIN  = 14'd9421;
  localparam logic [12:0] RST_CRUISE_DUTY = 13'd2908;
  localparam logic [12:0] RST_CURVE_SLOW  = 13'd492;
  localparam logic [12:0] RST_STALL_FLOOR = 13'd2087;
  localparam logic [12:0] RST_SPEED_SCALE = 13'd3215;
  localparam logic [11:0] RST_WHITE_LEVEL = 12'd3277;
  localparam logic [13:0] RST_OBST_RANGE  = 14'd424;

  localparam int DIV_NW = 26;
  localparam int DIV_DW = 15;

endpackage
`default_nettype wire

>>> rtl/lfpd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module lfpd_div #(
  parameter int NW = 26,
  parameter int DW = 15
) (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic          step,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic      [NW-1:0] quotient
);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    ge      = trial >= {1'b0, divisor};
    diff    = trial - {1'b0, divisor};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (load) begin
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (step) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/lfpd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module lfpd_mul #(
  parameter int MW = 14,
  parameter int AW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire logic signed [AW-1:0] mcand,
  input  wire logic        [MW-1:0] mplier,
  output logic signed      [AW-1:0] product
);

  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] mc_r, mc_nxt;
  logic        [MW-1:0] mp_r, mp_nxt;

  always_comb begin
    if (load) begin
      acc_nxt = '0;
      mc_nxt  = mcand;
      mp_nxt  = mplier;
    end else begin
      acc_nxt = mp_r[0] ? acc_r + mc_r : acc_r;
      mc_nxt  = mc_r <<< 1;
      mp_nxt  = mp_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign product = acc_r;

endmodule
`default_nettype wire

>>> rtl/line_follow_pd_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Line follower control step, one transaction per control tick.
// The input channel carries the five reflectance samples and the sonar range in
// in_tdata and the echo flag in in_tuser. Each accepted tick gives exactly one
// result transaction on the output channel. The cfg channel writes the eight
// tuning registers and is always ready; write it only while the block is idle.
// A following tick runs the bit-serial divide of the weighted position, the
// serial multiplies of the gains in one multiplier per gain, the serial speed
// scaling and the control states between them. Cross, lost, avoid and halted
// ticks skip the divide and the gain multiply. One tick is worked on at a
// time, so the next tick is not accepted until the result has been written.
// A finished result sits in the output register until it is taken, and the
// next tick may be accepted meanwhile; the sequencer waits before writing the
// output register again while the receiver stalls.
// Synchronous reset restores the register defaults, clears the steering and
// goal state, reloads the start grace count and drops any pending result.
module line_follow_pd_step #(
  parameter int PING_PERIOD        = 2,
  parameter int BAR_WINDOW_TICKS   = 50,
  parameter int START_IGNORE_TICKS = 200,
  parameter int CONFIRM_COUNT      = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // far_left_sample, near_left_sample, center_sample, near_right_sample,
  // far_right_sample, range_reading, zero padding
  input  wire logic [79:0] in_tdata,
  // echo_seen
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // left_duty, right_duty, action_code, line_error, steer_amount, zero padding
  output logic [63:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

`include "line_follow_pd_step_assert.svh"

  localparam int PW  = $clog2(PING_PERIOD + 1);
  localparam int SW  = $clog2(CONFIRM_COUNT + 1);
  localparam int BWW = $clog2(BAR_WINDOW_TICKS + 1);
  localparam int SIW = $clog2(START_IGNORE_TICKS + 2);
  localparam int DIV_LAST   = lfpd_pkg::DIV_NW - 1;
  localparam int MUL_LAST   = 13;
  localparam int SCALE_LAST = 12;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_DIV, ST_ERR, ST_MUL, ST_STEER, ST_DRIVE, ST_SCALE, ST_FIN
  } state_t;

  function automatic logic signed [31:0] rescale(input logic signed [31:0] x);
    logic [31:0] m;
    begin
      if (!x[31]) begin
        rescale = (x + 32'sd2048) >>> 12;
      end else begin
        m = (32'd0 - x) + 32'd2048;
        rescale = 32'sd0 - $signed({12'd0, m[31:12]});
      end
    end
  endfunction

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  logic [13:0] prop_gain_r, deriv_gain_r, obst_range_r;
  logic [12:0] cruise_r, curve_r, stall_r, scale_r;
  logic [11:0] white_r;

  logic [11:0] s_r [5];
  logic [13:0] rng_r;
  logic        echo_r;

  logic signed [14:0] prev_err_r, prev_err_nxt;
  lfpd_pkg::side_t    side_r, side_nxt;
  logic               prev_aw_r, prev_aw_nxt;
  logic [BWW-1:0]     bw_r, bw_nxt;
  logic [SIW-1:0]     si_r, si_nxt;
  logic [PW-1:0]      ping_r, ping_nxt;
  logic [SW-1:0]      streak_r, streak_nxt;
  logic               halted_r, halted_nxt;

  logic                neg_r, neg_nxt;
  logic signed [19:0]  l_r, l_nxt, r_r, r_nxt;
  logic [12:0]         cl_r, cl_nxt, cr_r, cr_nxt;
  lfpd_pkg::action_t   act_r, act_nxt;
  logic signed [14:0]  err_r, err_nxt;
  logic signed [16:0]  corr_r, corr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [12:0]         out_left_r, out_left_nxt, out_right_r, out_right_nxt;
  lfpd_pkg::action_t   out_act_r, out_act_nxt;
  logic signed [14:0]  out_err_r, out_err_nxt;
  logic signed [16:0]  out_corr_r, out_corr_nxt;

  logic        w [5];
  logic [11:0] a [5];
  logic [14:0] sum;
  logic signed [15:0] num;
  logic [13:0] num_abs;
  logic        full_white, edge_seen, close_seen, fire_now, fire, check;
  logic [PW-1:0] ping_inc;
  logic [SW-1:0] streak_inc;
  logic [SIW-1:0] si_dec;
  logic [BWW-1:0] bw_dec;

  logic        div_load, div_step, mul_load, scale_load;
  logic [lfpd_pkg::DIV_NW-1:0] div_quo;
  logic signed [14:0] err_c;
  logic signed [15:0] diff_c;
  logic [13:0] mag_c;
  logic signed [31:0] pd_prod;
  logic signed [27:0] cs_prod;
  logic signed [26:0] sl_prod, sr_prod;
  logic signed [31:0] corr_wide, cs_resc;
  logic signed [16:0] corr_c;
  logic signed [19:0] base_c, faster, boost, lb, rb;
  logic [26:0] sl_rnd, sr_rnd;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {3'd0, out_corr_r, out_err_r, out_act_r, out_right_r, out_left_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= lfpd_pkg::RST_PROP_GAIN;
      deriv_gain_r <= lfpd_pkg::RST_DERIV_GAIN;
      cruise_r     <= lfpd_pkg::RST_CRUISE_DUTY;
      curve_r      <= lfpd_pkg::RST_CURVE_SLOW;
      stall_r      <= lfpd_pkg::RST_STALL_FLOOR;
      scale_r      <= lfpd_pkg::RST_SPEED_SCALE;
      white_r      <= lfpd_pkg::RST_WHITE_LEVEL;
      obst_range_r <= lfpd_pkg::RST_OBST_RANGE;
    end else if (cfg_valid) begin
      case (cfg_index)
        lfpd_pkg::CFG_PROP_GAIN:   prop_gain_r  <= cfg_data;
        lfpd_pkg::CFG_DERIV_GAIN:  deriv_gain_r <= cfg_data;
        lfpd_pkg::CFG_CRUISE_DUTY: cruise_r     <= cfg_data[12:0];
        lfpd_pkg::CFG_CURVE_SLOW:  curve_r      <= cfg_data[12:0];
        lfpd_pkg::CFG_STALL_FLOOR: stall_r      <= cfg_data[12:0];
        lfpd_pkg::CFG_SPEED_SCALE: scale_r      <= cfg_data[12:0];
        lfpd_pkg::CFG_WHITE_LEVEL: white_r      <= cfg_data[11:0];
        lfpd_pkg::CFG_OBST_RANGE:  obst_range_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      for (int i = 0; i < 5; i++) begin
        s_r[i] <= in_tdata[12*i +: 12];
      end
      rng_r  <= in_tdata[73:60];
      echo_r <= in_tuser[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      w[i] = s_r[i] > white_r;
    end
    for (int i = 0; i < 5; i++) begin
      if (i == 2) begin
        a[i] = (s_r[i] > lfpd_pkg::FLOOR_MID) ? s_r[i] - lfpd_pkg::FLOOR_MID : 12'd0;
      end else begin
        a[i] = (s_r[i] > lfpd_pkg::FLOOR_SIDE) ? s_r[i] - lfpd_pkg::FLOOR_SIDE : 12'd0;
      end
    end
    sum = {3'd0, a[0]} + {3'd0, a[1]} + {3'd0, a[2]} + {3'd0, a[3]} + {3'd0, a[4]};
    num = $signed({4'd0, a[3]}) + $signed({4'd0, a[4]}) + $signed({4'd0, a[4]})
        - $signed({4'd0, a[1]}) - $signed({4'd0, a[0]}) - $signed({4'd0, a[0]});
    num_abs = num[15] ? 14'(16'd0 - num) : num[13:0];
    full_white = w[0] && w[1] && w[2] && w[3] && w[4];
    edge_seen = full_white && !prev_aw_r;
    ping_inc = ping_r + PW'(1);
    check = ping_inc >= PW'(PING_PERIOD);
    close_seen = echo_r && (rng_r > lfpd_pkg::NOISE_RANGE) && (rng_r < obst_range_r);
    fire_now = rng_r < lfpd_pkg::EMERG_RANGE;
    streak_inc = streak_r + SW'(1);
    fire = close_seen && (fire_now || (streak_inc >= SW'(CONFIRM_COUNT)));
    si_dec = (si_r != '0) ? si_r - SIW'(1) : si_r;
    bw_dec = (bw_r != '0) ? bw_r - BWW'(1) : bw_r;
  end

  always_comb begin
    err_c  = neg_r ? 15'(15'sd0 - $signed({1'b0, div_quo[13:0]}))
                   : $signed({1'b0, div_quo[13:0]});
    diff_c = 16'(err_c) - 16'(prev_err_r);
    mag_c  = err_c[14] ? 14'(15'sd0 - err_c) : err_c[13:0];
    corr_wide = rescale(pd_prod);
    if (corr_wide > 32'(lfpd_pkg::STEER_LIM)) begin
      corr_c = lfpd_pkg::STEER_LIM;
    end else if (corr_wide < 32'(-lfpd_pkg::STEER_LIM)) begin
      corr_c = -lfpd_pkg::STEER_LIM;
    end else begin
      corr_c = corr_wide[16:0];
    end
    cs_resc = rescale(32'(cs_prod));
    base_c  = $signed({7'd0, cruise_r}) - cs_resc[19:0];
    faster  = (l_r > r_r) ? l_r : r_r;
    boost   = ((faster > 20'sd0) && (faster < $signed({7'd0, stall_r})))
            ? $signed({7'd0, stall_r}) - faster : 20'sd0;
    lb = l_r + boost;
    rb = r_r + boost;
    sl_rnd = sl_prod + 27'd2048;
    sr_rnd = sr_prod + 27'd2048;
  end

  assign div_load   = (state_r == ST_DECIDE);
  assign div_step   = (state_r == ST_DIV);
  assign mul_load   = (state_r == ST_ERR);
  assign scale_load = (state_r == ST_DRIVE);

  lfpd_div #(.NW(lfpd_pkg::DIV_NW), .DW(lfpd_pkg::DIV_DW)) u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (div_step),
    .dividend ({num_abs, 12'd0}),
    .divisor  (sum),
    .quotient (div_quo)
  );

  logic signed [31:0] kp_prod, kd_prod;

  lfpd_mul #(.MW(14), .AW(32)) u_mul_kp (
    .clk (clk), .load (mul_load), .mcand (32'(err_c)), .mplier (prop_gain_r),
    .product (kp_prod)
  );

  lfpd_mul #(.MW(14), .AW(32)) u_mul_kd (
    .clk (clk), .load (mul_load), .mcand (32'(diff_c)), .mplier (deriv_gain_r),
    .product (kd_prod)
  );

  lfpd_mul #(.MW(14), .AW(28)) u_mul_cs (
    .clk (clk), .load (mul_load), .mcand ($signed({14'd0, mag_c})),
    .mplier ({1'b0, curve_r}), .product (cs_prod)
  );

  assign pd_prod = kp_prod + kd_prod;

  lfpd_mul #(.MW(13), .AW(27)) u_scale_l (
    .clk (clk), .load (scale_load), .mcand ($signed({14'd0, cl_nxt})),
    .mplier (scale_r), .product (sl_prod)
  );

  lfpd_mul #(.MW(13), .AW(27)) u_scale_r (
    .clk (clk), .load (scale_load), .mcand ($signed({14'd0, cr_nxt})),
    .mplier (scale_r), .product (sr_prod)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    prev_err_nxt  = prev_err_r;
    side_nxt      = side_r;
    prev_aw_nxt   = prev_aw_r;
    bw_nxt        = bw_r;
    si_nxt        = si_r;
    ping_nxt      = ping_r;
    streak_nxt    = streak_r;
    halted_nxt    = halted_r;
    neg_nxt       = neg_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    cl_nxt        = cl_r;
    cr_nxt        = cr_r;
    act_nxt       = act_r;
    err_nxt       = err_r;
    corr_nxt      = corr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_act_nxt   = out_act_r;
    out_err_nxt   = out_err_r;
    out_corr_nxt  = out_corr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        err_nxt   = '0;
        corr_nxt  = '0;
        l_nxt     = '0;
        r_nxt     = '0;
        state_nxt = ST_DRIVE;
        if (halted_r) begin
          act_nxt = lfpd_pkg::ACT_HALTED;
        end else if (check && fire) begin
          ping_nxt     = '0;
          streak_nxt   = '0;
          prev_err_nxt = '0;
          side_nxt     = lfpd_pkg::SIDE_CENTER;
          act_nxt = (rng_r < lfpd_pkg::DIAG_RANGE) ? lfpd_pkg::ACT_AVOID_DIAG
                                                   : lfpd_pkg::ACT_AVOID;
        end else begin
          if (check) begin
            ping_nxt = '0;
            if (close_seen) begin
              streak_nxt = streak_inc;
            end else if (streak_r != '0) begin
              streak_nxt = streak_r - SW'(1);
            end
          end else begin
            ping_nxt = ping_inc;
          end
          si_nxt      = si_dec;
          prev_aw_nxt = full_white;
          bw_nxt      = bw_dec;
          if (edge_seen && (si_dec == '0) && (bw_dec != '0)) begin
            halted_nxt = 1'b1;
            act_nxt    = lfpd_pkg::ACT_HALTED;
          end else begin
            if (edge_seen && (si_dec == '0)) begin
              bw_nxt = BWW'(BAR_WINDOW_TICKS);
            end
            if (w[0] && w[4]) begin
              l_nxt        = $signed({7'd0, cruise_r});
              r_nxt        = $signed({7'd0, cruise_r});
              prev_err_nxt = '0;
              side_nxt     = lfpd_pkg::SIDE_CENTER;
              act_nxt      = lfpd_pkg::ACT_CROSS;
            end else if (sum > lfpd_pkg::LINE_MIN_SUM) begin
              neg_nxt = num[15];
              if (w[0] && !w[4]) begin
                side_nxt = lfpd_pkg::SIDE_LEFT;
              end else if (w[4] && !w[0]) begin
                side_nxt = lfpd_pkg::SIDE_RIGHT;
              end else if (w[1] || w[2] || w[3]) begin
                side_nxt = lfpd_pkg::SIDE_CENTER;
              end
              act_nxt   = lfpd_pkg::ACT_FOLLOW;
              cnt_nxt   = '0;
              state_nxt = ST_DIV;
            end else begin
              prev_err_nxt = '0;
              if (side_r == lfpd_pkg::SIDE_RIGHT) begin
                l_nxt   = $signed({7'd0, cruise_r});
                act_nxt = lfpd_pkg::ACT_LOST_RIGHT;
              end else if (side_r == lfpd_pkg::SIDE_LEFT) begin
                r_nxt   = $signed({7'd0, cruise_r});
                act_nxt = lfpd_pkg::ACT_LOST_LEFT;
              end else begin
                l_nxt   = $signed({7'd0, cruise_r});
                r_nxt   = $signed({7'd0, cruise_r});
                act_nxt = lfpd_pkg::ACT_LOST_STRAIT;
              end
            end
          end
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_LAST)) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        err_nxt      = err_c;
        prev_err_nxt = err_c;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(MUL_LAST)) begin
          state_nxt = ST_STEER;
        end
      end
      ST_STEER: begin
        corr_nxt  = corr_c;
        l_nxt     = base_c + 20'(corr_c);
        r_nxt     = base_c - 20'(corr_c);
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        cl_nxt = lb[19] ? 13'd0 : ((lb > 20'sd4096) ? lfpd_pkg::Q_ONE : lb[12:0]);
        cr_nxt = rb[19] ? 13'd0 : ((rb > 20'sd4096) ? lfpd_pkg::Q_ONE : rb[12:0]);
        cnt_nxt   = '0;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(SCALE_LAST)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = (sl_rnd[26:12] > 15'd4096) ? lfpd_pkg::Q_ONE : sl_rnd[24:12];
          out_right_nxt = (sr_rnd[26:12] > 15'd4096) ? lfpd_pkg::Q_ONE : sr_rnd[24:12];
          out_act_nxt   = act_r;
          out_err_nxt   = err_r;
          out_corr_nxt  = corr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      prev_err_r  <= '0;
      side_r      <= lfpd_pkg::SIDE_CENTER;
      prev_aw_r   <= 1'b0;
      bw_r        <= '0;
      si_r        <= SIW'(START_IGNORE_TICKS);
      ping_r      <= '0;
      streak_r    <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prev_err_r  <= prev_err_nxt;
      side_r      <= side_nxt;
      prev_aw_r   <= prev_aw_nxt;
      bw_r        <= bw_nxt;
      si_r        <= si_nxt;
      ping_r      <= ping_nxt;
      streak_r    <= streak_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r       <= neg_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    cl_r        <= cl_nxt;
    cr_r        <= cr_nxt;
    act_r       <= act_nxt;
    err_r       <= err_nxt;
    corr_r      <= corr_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_act_r   <= out_act_nxt;
    out_err_r   <= out_err_nxt;
    out_corr_r  <= out_corr_nxt;
  end

  `LFPD_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt state was released")
  `LFPD_ASSERT_ALWAYS(a_streak_bound, streak_r < SW'(CONFIRM_COUNT), "streak reached confirm")
  `LFPD_ASSERT_IMP(a_avoid_zero, out_valid_r && (out_act_r == lfpd_pkg::ACT_AVOID || out_act_r == lfpd_pkg::ACT_AVOID_DIAG), out_left_r == '0 && out_right_r == '0 && out_corr_r == '0, "avoid result not zero")

endmodule
`default_nettype wire
